// ===== src/assert_macros.svh =====
// Assertion helpers; define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define C8_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Check a property on every clock edge, reset included.
`define C8_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define C8_ASSERT(lbl, clk, rst, prop)
`define C8_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== src/c8_pkg.sv =====
`timescale 1ns / 1ps
package c8_pkg;
   localparam int MEM_BYTES   = 4096;
   localparam int STACK_DEPTH = 16;
   localparam int SCREEN_ROWS = 32;
   localparam int ADDR_W = $clog2(MEM_BYTES);
   localparam int SP_W   = $clog2(STACK_DEPTH);
   localparam int ROW_W  = $clog2(SCREEN_ROWS);

   localparam logic [11:0] PC_START  = 12'h200;
   localparam logic [15:0] FONT_BASE = 16'h0050;
   localparam logic [15:0] DIV_RESET = 16'd8;

   localparam logic [1:0] FN_LOAD = 2'd0;
   localparam logic [1:0] FN_EXEC = 2'd1;
   localparam logic [1:0] FN_ROW  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNIMP = 2'd1;
   localparam logic [1:0] ST_OVER  = 2'd2;
   localparam logic [1:0] ST_UNDER = 2'd3;

   localparam logic [3:0] OP_SYS  = 4'h0;
   localparam logic [3:0] OP_JP   = 4'h1;
   localparam logic [3:0] OP_CALL = 4'h2;
   localparam logic [3:0] OP_SEI  = 4'h3;
   localparam logic [3:0] OP_SNEI = 4'h4;
   localparam logic [3:0] OP_SER  = 4'h5;
   localparam logic [3:0] OP_LDI  = 4'h6;
   localparam logic [3:0] OP_ADDI = 4'h7;
   localparam logic [3:0] OP_ALU  = 4'h8;
   localparam logic [3:0] OP_SNER = 4'h9;
   localparam logic [3:0] OP_LDIX = 4'hA;
   localparam logic [3:0] OP_JPV0 = 4'hB;
   localparam logic [3:0] OP_RND  = 4'hC;
   localparam logic [3:0] OP_DRW  = 4'hD;
   localparam logic [3:0] OP_KEY  = 4'hE;
   localparam logic [3:0] OP_MISC = 4'hF;

   localparam logic [11:0] SYS_CLS = 12'h0E0;
   localparam logic [11:0] SYS_RET = 12'h0EE;

   localparam logic [3:0] AL_MOV = 4'h0;
   localparam logic [3:0] AL_OR  = 4'h1;
   localparam logic [3:0] AL_AND = 4'h2;
   localparam logic [3:0] AL_XOR = 4'h3;
   localparam logic [3:0] AL_ADD = 4'h4;
   localparam logic [3:0] AL_SUB = 4'h5;
   localparam logic [3:0] AL_SHR = 4'h6;
   localparam logic [3:0] AL_SBN = 4'h7;
   localparam logic [3:0] AL_SHL = 4'hE;

   localparam logic [7:0] MS_GDT = 8'h07;
   localparam logic [7:0] MS_SDT = 8'h15;
   localparam logic [7:0] MS_SST = 8'h18;
   localparam logic [7:0] MS_ADI = 8'h1E;
   localparam logic [7:0] MS_FNT = 8'h29;
   localparam logic [7:0] MS_BCD = 8'h33;
   localparam logic [7:0] MS_STR = 8'h55;
   localparam logic [7:0] MS_LDR = 8'h65;

   typedef enum logic [3:0] {
      S_IDLE, S_ROW, S_F0, S_F1, S_F2, S_EXEC, S_DRD, S_DWR, S_FLAG,
      S_BCD, S_SRD, S_SWR, S_LRD, S_LWR, S_COMMIT, S_DONE
   } c8_state_type;

   typedef struct packed {
      logic [7:0] value;
      logic       flag;
      logic       has_flag;
      logic       legal;
   } c8_alu_type;
endpackage

// ===== src/c8_alu.sv =====
`timescale 1ns / 1ps
module c8_alu (
   input  logic [3:0]          fn,
   input  logic [7:0]          vx,
   input  logic [7:0]          vy,
   output c8_pkg::c8_alu_type  res
);
   import c8_pkg::*;

   logic [8:0] sum;

   assign sum = {1'b0, vx} + {1'b0, vy};

   always_comb begin
      res = '{value: vx, flag: 1'b0, has_flag: 1'b0, legal: 1'b1};
      case (fn)
         AL_MOV: res.value = vy;
         AL_OR:  res.value = vx | vy;
         AL_AND: res.value = vx & vy;
         AL_XOR: res.value = vx ^ vy;
         AL_ADD: begin
            res.value = sum[7:0]; res.flag = sum[8]; res.has_flag = 1'b1;
         end
         AL_SUB: begin
            res.value = vx - vy; res.flag = (vx >= vy); res.has_flag = 1'b1;
         end
         AL_SHR: begin
            res.value = {1'b0, vx[7:1]}; res.flag = vx[0]; res.has_flag = 1'b1;
         end
         AL_SBN: begin
            res.value = vy - vx; res.flag = (vy >= vx); res.has_flag = 1'b1;
         end
         AL_SHL: begin
            res.value = {vx[6:0], 1'b0}; res.flag = vx[7]; res.has_flag = 1'b1;
         end
         default: res.legal = 1'b0;
      endcase
   end
endmodule

// ===== src/chip8_instruction_executor_core.sv =====
`timescale 1ns / 1ps
// CHIP-8 core: 4 KiB RAM, V0..VF, I, PC, a 16-deep return stack, a 64x32
// frame and the delay/sound timers, driven by a single sequencer; RAM, V
// registers, stack and frame are synchronous memories. A RAM load writes
// in S_IDLE, a row read passes S_ROW; an instruction is fetched, reads
// registers, executes and commits, plus a flag write, a RAM read and frame
// write per sprite row on Dxyn, a RAM write per digit on Fx33 and a read
// and write per register on Fx55/Fx65, since each step uses the RAM's one
// read or one write port and the register file's one write port. A finished
// result sits in the output register while the next item is taken. Reset
// needs no clearing pass: each frame row and register carries a valid bit.
`include "assert_macros.svh"
module chip8_instruction_executor_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [11:0] req_address,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_random_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_program_counter,
   output logic [63:0] rsp_display_row,
   output logic        rsp_draw_flag,
   output logic        rsp_sound_active,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import c8_pkg::*;

   c8_state_type state_ff, state_in;

   logic [11:0] pc_ff, pc_in, next_ff, next_in, addr_ff, addr_in;
   logic [15:0] idx_ff, idx_in, tick_ff, tick_in, div_ff, div_in;
   logic [4:0]  sp_ff, sp_in;
   logic [7:0]  delay_ff, delay_in, sound_ff, sound_in, rnd_ff, rnd_in;
   logic [7:0]  op_hi_ff, op_hi_in, vx_ff, vx_in, vy_ff, vy_in, flag_ff, flag_in;
   logic [15:0] op_ff, op_in;
   logic [3:0]  cnt_ff, cnt_in, bh_ff, bh_in, bt_ff, bt_in, bo_ff, bo_in;
   logic        hit_ff, hit_in, draw_ff, draw_in;
   logic [1:0]  status_ff, status_in;
   logic [63:0] row_ff, row_in;

   logic        rv_ff, rv_in, rdraw_ff, rdraw_in, rsnd_ff, rsnd_in;
   logic [1:0]  rst_ff, rst_in;
   logic [11:0] rpc_ff, rpc_in;
   logic [63:0] rrow_ff, rrow_in;

   // main RAM
   logic [7:0]        ram [MEM_BYTES];
   logic [7:0]        ram_q_ff, ram_wd;
   logic [ADDR_W-1:0] ram_ra, ram_wa;
   logic              ram_we;

   // data registers, with valid bits standing in for the zero reset
   logic [7:0]  vreg [16];
   logic [7:0]  vqa_raw_ff, vqb_raw_ff, vqa, vqb, v_wd;
   logic        vqa_ok_ff, vqb_ok_ff, v_we;
   logic [3:0]  v_ra, v_rb, v_wa;
   logic [15:0] vval_ff;

   // return stack
   logic [11:0]     stk [STACK_DEPTH];
   logic [11:0]     stk_q_ff;
   logic [SP_W-1:0] stk_ra, stk_wa;
   logic            stk_we;

   // frame rows, with valid bits so a clear drops every row at once
   logic [63:0]            frame [SCREEN_ROWS];
   logic [63:0]            fr_q_ff, fr_wd;
   logic                   fr_ok_ff, fr_we, fr_clr;
   logic [ROW_W-1:0]       fr_ra, fr_wa;
   logic [SCREEN_ROWS-1:0] frv_ff;

   c8_alu_type alu_res;

   logic [3:0]   ox, oy, on;
   logic [7:0]   okk;
   logic [11:0]  onnn;
   logic [15:0]  opc;
   logic [7:0]   spr, brem;
   logic [63:0]  pix, cur;
   logic [127:0] rot;
   logic [15:0]  tick_nx;
   logic [14:0]  tmul;
   logic [6:0]   bten;

   assign ox   = op_ff[11:8];
   assign oy   = op_ff[7:4];
   assign on   = op_ff[3:0];
   assign okk  = op_ff[7:0];
   assign onnn = op_ff[11:0];
   assign vqa  = vqa_ok_ff ? vqa_raw_ff : 8'd0;
   assign vqb  = vqb_ok_ff ? vqb_raw_ff : 8'd0;
   assign opc  = {op_hi_ff, ram_q_ff};

   c8_alu u_alu (.fn(on), .vx(vqa), .vy(vqb), .res(alu_res));

   always_ff @(posedge clock) begin
      if (ram_we) ram[ram_wa] <= ram_wd;
      ram_q_ff <= ram[ram_ra];
   end

   always_ff @(posedge clock) begin
      if (v_we) vreg[v_wa] <= v_wd;
      vqa_raw_ff <= vreg[v_ra];
      vqb_raw_ff <= vreg[v_rb];
      vqa_ok_ff  <= vval_ff[v_ra];
      vqb_ok_ff  <= vval_ff[v_rb];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk[stk_wa] <= 12'(pc_ff);
      stk_q_ff <= stk[stk_ra];
   end

   always_ff @(posedge clock) begin
      if (fr_we) frame[fr_wa] <= fr_wd;
      fr_q_ff  <= frame[fr_ra];
      fr_ok_ff <= frv_ff[fr_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vval_ff <= '0;
         frv_ff  <= '0;
      end else begin
         if (v_we) vval_ff[v_wa] <= 1'b1;
         if (fr_clr) frv_ff <= '0;
         else if (fr_we) frv_ff[fr_wa] <= 1'b1;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;     next_in  = next_ff;  addr_in  = addr_ff;
      idx_in    = idx_ff;    tick_in  = tick_ff;  sp_in    = sp_ff;
      delay_in  = delay_ff;  sound_in = sound_ff; rnd_in   = rnd_ff;
      op_hi_in  = op_hi_ff;  op_in    = op_ff;    vx_in    = vx_ff;
      vy_in     = vy_ff;     flag_in  = flag_ff;  cnt_in   = cnt_ff;
      bh_in     = bh_ff;     bt_in    = bt_ff;    bo_in    = bo_ff;
      hit_in    = hit_ff;    draw_in  = draw_ff;  status_in = status_ff;
      row_in    = row_ff;
      div_in    = csr_write_enable ? csr_write_data : div_ff;
      rv_in     = rv_ff && !rsp_ready;
      rst_in    = rst_ff;    rpc_in   = rpc_ff;   rrow_in  = rrow_ff;
      rdraw_in  = rdraw_ff;  rsnd_in  = rsnd_ff;
      req_ready = 1'b0;
      ram_we = 1'b0; ram_ra = pc_ff; ram_wa = pc_ff; ram_wd = 8'd0;
      v_we = 1'b0; v_wa = ox; v_wd = 8'd0; v_ra = ox; v_rb = oy;
      stk_we = 1'b0; stk_wa = sp_ff[SP_W-1:0]; stk_ra = SP_W'(sp_ff - 5'd1);
      fr_we = 1'b0; fr_clr = 1'b0; fr_wa = '0; fr_wd = '0;
      fr_ra = ROW_W'(vy_ff + 8'(cnt_ff));
      spr = '0; pix = '0; cur = '0; rot = '0; tick_nx = '0;
      brem = '0; tmul = '0; bten = '0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               addr_in   = req_address;
               rnd_in    = req_random_byte;
               status_in = ST_OK;
               draw_in   = 1'b0;
               row_in    = '0;
               fr_ra     = req_address[ROW_W-1:0];
               case (req_func)
                  FN_LOAD: begin
                     ram_we = 1'b1; ram_wa = req_address; ram_wd = req_data_byte;
                     state_in = S_DONE;
                  end
                  FN_EXEC: state_in = S_F0;
                  FN_ROW:  state_in = S_ROW;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_ROW: begin
            if (addr_ff < 12'(SCREEN_ROWS) && fr_ok_ff) row_in = fr_q_ff;
            state_in = S_DONE;
         end
         S_F0: begin
            state_in = S_F1;
         end
         S_F1: begin
            op_hi_in = ram_q_ff;
            ram_ra = pc_ff + 12'd1;
            state_in = S_F2;
         end
         S_F2: begin
            op_in = opc;
            v_ra  = (opc[15:12] == OP_JPV0) ? 4'd0 : opc[11:8];
            v_rb  = opc[7:4];
            state_in = S_EXEC;
         end
         S_EXEC: begin
            vx_in    = vqa;
            vy_in    = vqb;
            next_in  = pc_ff + 12'd2;
            cnt_in   = '0;
            state_in = S_COMMIT;
            case (op_ff[15:12])
               OP_SYS: begin
                  if (onnn == SYS_CLS) begin
                     fr_clr = 1'b1; draw_in = 1'b1;
                  end else if (onnn == SYS_RET) begin
                     if (sp_ff == 5'd0) begin
                        status_in = ST_UNDER; state_in = S_DONE;
                     end else begin
                        sp_in   = sp_ff - 5'd1;
                        next_in = stk_q_ff + 12'd2;
                     end
                  end else begin
                     status_in = ST_UNIMP; state_in = S_DONE;
                  end
               end
               OP_JP: next_in = onnn;
               OP_CALL: begin
                  if (sp_ff >= 5'(STACK_DEPTH)) begin
                     status_in = ST_OVER; state_in = S_DONE;
                  end else begin
                     stk_we = 1'b1; sp_in = sp_ff + 5'd1; next_in = onnn;
                  end
               end
               OP_SEI:  if (vqa == okk) next_in = pc_ff + 12'd4;
               OP_SNEI: if (vqa != okk) next_in = pc_ff + 12'd4;
               OP_SER:  if (vqa == vqb) next_in = pc_ff + 12'd4;
               OP_SNER: if (vqa != vqb) next_in = pc_ff + 12'd4;
               OP_LDI:  begin v_we = 1'b1; v_wd = okk; end
               OP_ADDI: begin v_we = 1'b1; v_wd = vqa + okk; end
               OP_RND:  begin v_we = 1'b1; v_wd = rnd_ff & okk; end
               OP_ALU: begin
                  if (!alu_res.legal) begin
                     status_in = ST_UNIMP; state_in = S_DONE;
                  end else begin
                     v_we = 1'b1; v_wd = alu_res.value;
                     flag_in = {7'd0, alu_res.flag};
                     if (alu_res.has_flag) state_in = S_FLAG;
                  end
               end
               OP_LDIX: idx_in = {4'd0, onnn};
               OP_JPV0: next_in = onnn + {4'd0, vqa};
               OP_DRW: begin
                  draw_in = 1'b1;
                  hit_in  = 1'b0;
                  flag_in = 8'd0;
                  state_in = (on == 4'd0) ? S_FLAG : S_DRD;
               end
               OP_KEY: begin
                  status_in = ST_UNIMP; state_in = S_DONE;
               end
               default: begin
                  case (okk)
                     MS_GDT: begin v_we = 1'b1; v_wd = delay_ff; end
                     MS_SDT: delay_in = vqa;
                     MS_SST: sound_in = vqa;
                     MS_ADI: idx_in = idx_ff + {8'd0, vqa};
                     MS_FNT: idx_in = FONT_BASE + {10'd0, vqa[3:0], 2'd0}
                                      + {12'd0, vqa[3:0]};
                     MS_BCD: begin
                        if (vqa >= 8'd200) begin
                           bh_in = 4'd2; brem = vqa - 8'd200;
                        end else if (vqa >= 8'd100) begin
                           bh_in = 4'd1; brem = vqa - 8'd100;
                        end else begin
                           bh_in = 4'd0; brem = vqa;
                        end
                        // tens by reciprocal multiply, exact below 100
                        tmul  = 15'(brem) * 15'd205;
                        bt_in = tmul[14:11];
                        bten  = 7'({bt_in, 3'd0}) + 7'({bt_in, 1'b0});
                        bo_in = 4'(brem[6:0] - bten);
                        state_in = S_BCD;
                     end
                     MS_STR: state_in = S_SRD;
                     MS_LDR: state_in = S_LRD;
                     default: begin
                        status_in = ST_UNIMP; state_in = S_DONE;
                     end
                  endcase
               end
            endcase
         end
         S_DRD: begin
            ram_ra   = idx_ff[11:0] + 12'(cnt_ff);
            state_in = S_DWR;
         end
         S_DWR: begin
            spr = {<<{ram_q_ff}};
            rot = {pix, pix};
            pix = {56'd0, spr};
            rot = {pix, pix} << vx_ff[5:0];
            cur = fr_ok_ff ? fr_q_ff : 64'd0;
            hit_in = hit_ff | (|(cur & rot[127:64]));
            fr_we = 1'b1;
            fr_wa = ROW_W'(vy_ff + 8'(cnt_ff));
            fr_wd = cur ^ rot[127:64];
            if (cnt_ff == on - 4'd1) begin
               flag_in  = {7'd0, hit_in};
               state_in = S_FLAG;
            end else begin
               cnt_in   = cnt_ff + 4'd1;
               state_in = S_DRD;
            end
         end
         S_FLAG: begin
            v_we = 1'b1; v_wa = 4'hF; v_wd = flag_ff;
            state_in = S_COMMIT;
         end
         S_BCD: begin
            ram_we = 1'b1;
            ram_wa = idx_ff[11:0] + 12'(cnt_ff);
            ram_wd = (cnt_ff == 4'd0) ? {4'd0, bh_ff} :
                     (cnt_ff == 4'd1) ? {4'd0, bt_ff} : {4'd0, bo_ff};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd2) state_in = S_COMMIT;
         end
         S_SRD: begin
            v_ra = cnt_ff;
            state_in = S_SWR;
         end
         S_SWR: begin
            ram_we = 1'b1;
            ram_wa = idx_ff[11:0] + 12'(cnt_ff);
            ram_wd = vqa;
            cnt_in = cnt_ff + 4'd1;
            state_in = (cnt_ff == ox) ? S_COMMIT : S_SRD;
         end
         S_LRD: begin
            ram_ra = idx_ff[11:0] + 12'(cnt_ff);
            state_in = S_LWR;
         end
         S_LWR: begin
            v_we = 1'b1; v_wa = cnt_ff; v_wd = ram_q_ff;
            cnt_in = cnt_ff + 4'd1;
            state_in = (cnt_ff == ox) ? S_COMMIT : S_LRD;
         end
         S_COMMIT: begin
            pc_in   = next_ff;
            tick_nx = tick_ff + 16'd1;
            if (tick_nx >= div_ff) begin
               tick_in = '0;
               if (delay_ff != 8'd0) delay_in = delay_ff - 8'd1;
               if (sound_ff != 8'd0) sound_in = sound_ff - 8'd1;
            end else begin
               tick_in = tick_nx;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rv_ff || rsp_ready) begin
               rv_in    = 1'b1;
               rst_in   = status_ff;
               rpc_in   = pc_ff;
               rrow_in  = row_ff;
               rdraw_in = draw_ff;
               rsnd_in  = (sound_ff != 8'd0);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff    <= PC_START;
         idx_ff   <= '0;
         tick_ff  <= '0;
         div_ff   <= DIV_RESET;
         sp_ff    <= '0;
         delay_ff <= '0;
         sound_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         idx_ff   <= idx_in;
         tick_ff  <= tick_in;
         div_ff   <= div_in;
         sp_ff    <= sp_in;
         delay_ff <= delay_in;
         sound_ff <= sound_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      next_ff  <= next_in;  addr_ff  <= addr_in;  rnd_ff    <= rnd_in;
      op_hi_ff <= op_hi_in; op_ff    <= op_in;    vx_ff     <= vx_in;
      vy_ff    <= vy_in;    flag_ff  <= flag_in;  cnt_ff    <= cnt_in;
      bh_ff    <= bh_in;    bt_ff    <= bt_in;    bo_ff     <= bo_in;
      hit_ff   <= hit_in;   draw_ff  <= draw_in;  status_ff <= status_in;
      row_ff   <= row_in;   rst_ff   <= rst_in;   rpc_ff    <= rpc_in;
      rrow_ff  <= rrow_in;  rdraw_ff <= rdraw_in; rsnd_ff   <= rsnd_in;
   end

   assign rsp_valid           = rv_ff;
   assign rsp_status          = rst_ff;
   assign rsp_program_counter = rpc_ff;
   assign rsp_display_row     = rrow_ff;
   assign rsp_draw_flag       = rdraw_ff;
   assign rsp_sound_active    = rsnd_ff;

   `C8_ASSERT(a_sp_bound, clock, reset, sp_ff <= 5'(STACK_DEPTH))
   `C8_ASSERT(a_frame_wr_draw, clock, reset, fr_we |-> state_ff == S_DWR)
   `C8_ASSERT(a_done_loads_rsp, clock, reset,
      (state_ff == S_DONE && (!rv_ff || rsp_ready)) |=> (rv_ff && state_ff == S_IDLE))
endmodule
